// ----- src/interval_set_coverage_table_defines.svh -----
// Assertion macros for the interval set coverage table
`ifndef INTERVAL_SET_COVERAGE_TABLE_DEFINES_SVH
`define INTERVAL_SET_COVERAGE_TABLE_DEFINES_SVH
`define ISCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("%m: lbl");
`define ISCT_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error("%m: lbl");
`endif

// ----- src/isct_pkg.sv -----
// Shared types and constants of the interval set coverage table
package isct_pkg;
  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned CoordBitsDef = 32;
  localparam logic [2:0] ActFill = 3'd0;
  localparam logic [2:0] ActClear = 3'd1;
  localparam logic [2:0] ActPoint = 3'd2;
  localparam logic [2:0] ActAny = 3'd3;
  localparam logic [2:0] ActAll = 3'd4;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBad = 2'd2;
endpackage

// ----- src/interval_set_coverage_table.sv -----
// Interval set coverage table top level: sequencer and store
// Each transaction walks the stored intervals once: the store read is registered, then one
// entry is handled a cycle, with an extra beat when a fill lands before a stored entry or a
// clear splits one; a done state then registers the result.
// Ignored ranges and unused actions give their result straight after the accepting edge.
// One transaction at a time: the next is taken the cycle after the result is taken.
// Fill and clear write the new list into the other bank and swap at the end unless it overflows.
// Reset clears the count and bank select; stored entries are undefined.
module interval_set_coverage_table #(
  parameter int unsigned MAX_RANGES = isct_pkg::MaxRangesDef,
  parameter int unsigned COORD_BITS = isct_pkg::CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        answer_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entries_used_o
);
  import isct_pkg::*;
  `include "interval_set_coverage_table_defines.svh"

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 3);
  localparam int unsigned CB = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam logic [CW-1:0] MaxN = CW'(MAX_RANGES);

  typedef enum logic [1:0] {SIdle, SWalk, SDone} state_e;
  state_e state_q;
  logic bank_q, placed_q, hit_q, full_q;
  logic [2:0] act_q;
  logic [CB-1:0] l_q, r_q, lo_q, hi_q;
  logic [CW-1:0] cnt_q, idx_q, n_q;
  logic rdv_q;
  logic [2*CB-1:0] rd_data, wr_data;
  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic out_v_q, ans_q;
  logic [1:0] st_q;
  logic [4:0] used_q;

  isct_mem #(.Depth(MAX_RANGES), .Width(2*CB)) u_mem (
    .clk_i, .rd_bank_i(bank_q), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_bank_i(~bank_q), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  logic [CB-1:0] e_lo, e_hi, in_l, in_r;
  assign e_lo = rd_data[2*CB-1:CB];
  assign e_hi = rd_data[CB-1:0];
  assign in_l = range_low_i[CB-1:0];
  assign in_r = range_high_i[CB-1:0];
  assign rd_addr = idx_q[AW-1:0];
  assign in_stall_o = (state_q != SIdle) || out_v_q;
  logic modify;
  assign modify = (act_q == ActFill) || (act_q == ActClear);
  logic last;
  assign last = rdv_q && (idx_q > cnt_q);
  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // write generation for one entry per cycle (fill or clear may emit two; handled by a
  // second beat using the split flag)
  logic split_q;
  logic [CB-1:0] sp_lo_q, sp_hi_q;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = n_q[AW-1:0];
    wr_data = rd_data;
    if (state_q == SWalk && modify && !full_q) begin
      if (split_q) begin
        wr_en = n_q < MaxN; wr_data = {sp_lo_q, sp_hi_q};
      end else if (rdv_q && idx_q <= cnt_q && idx_q != '0) begin
        if (act_q == ActFill) begin
          if (e_hi < l_q) begin
            wr_en = n_q < MaxN;
          end else if (e_lo > r_q) begin
            wr_en = n_q < MaxN;
            if (!placed_q) wr_data = {lo_q, hi_q};
          end
        end else begin
          if (e_hi < l_q || e_lo > r_q) begin
            wr_en = n_q < MaxN;
          end else if (e_lo < l_q) begin
            wr_en = n_q < MaxN; wr_data = {e_lo, l_q - 1'b1};
          end else if (e_hi > r_q) begin
            wr_en = n_q < MaxN; wr_data = {r_q + 1'b1, e_hi};
          end
        end
      end else if (last && act_q == ActFill && !placed_q) begin
        wr_en = n_q < MaxN; wr_data = {lo_q, hi_q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; bank_q <= 1'b0; cnt_q <= '0; out_v_q <= 1'b0;
      idx_q <= '0; rdv_q <= 1'b0; split_q <= 1'b0;
      act_q <= ActFill; l_q <= '0; r_q <= '0; lo_q <= '0; hi_q <= '0;
      n_q <= '0; placed_q <= 1'b0; hit_q <= 1'b0; full_q <= 1'b0;
      sp_lo_q <= '0; sp_hi_q <= '0; ans_q <= 1'b0; st_q <= StOk; used_q <= '0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        SIdle: if (accept) begin
          act_q <= action_i; l_q <= in_l; lo_q <= in_l; hi_q <= in_r;
          r_q <= (action_i == ActPoint) ? in_l : in_r;
          idx_q <= '0; rdv_q <= 1'b0; n_q <= '0; placed_q <= 1'b0;
          hit_q <= 1'b0; full_q <= 1'b0; split_q <= 1'b0;
          if (action_i > ActAll) begin
            ans_q <= 1'b0; st_q <= StOk; used_q <= 5'(cnt_q); out_v_q <= 1'b1;
          end else if (action_i != ActPoint && in_l > in_r) begin
            ans_q <= 1'b0; st_q <= StBad; used_q <= 5'(cnt_q); out_v_q <= 1'b1;
          end else begin
            state_q <= SWalk;
          end
        end
        SWalk: begin
          if (split_q) begin
            split_q <= 1'b0;
            if (n_q >= MaxN) full_q <= 1'b1; else n_q <= n_q + 1'b1;
            idx_q <= idx_q + 1'b1;
          end else if (last) begin
            if (act_q == ActFill && !placed_q) begin
              if (n_q >= MaxN) full_q <= 1'b1; else n_q <= n_q + 1'b1;
            end
            state_q <= SDone;
          end else begin
            rdv_q <= 1'b1;
            if (rdv_q && idx_q != '0) begin
              unique case (1'b1)
                act_q == ActFill: begin
                  if (e_hi < l_q) begin
                    if (n_q >= MaxN) full_q <= 1'b1; else n_q <= n_q + 1'b1;
                  end else if (e_lo > r_q) begin
                    if (!placed_q) begin
                      placed_q <= 1'b1; split_q <= 1'b1;
                      sp_lo_q <= e_lo; sp_hi_q <= e_hi;
                    end
                    if (n_q >= MaxN) full_q <= 1'b1; else n_q <= n_q + 1'b1;
                  end else begin
                    if (e_lo < lo_q) lo_q <= e_lo;
                    if (e_hi > hi_q) hi_q <= e_hi;
                  end
                end
                act_q == ActClear: begin
                  if (e_hi < l_q || e_lo > r_q) begin
                    if (n_q >= MaxN) full_q <= 1'b1; else n_q <= n_q + 1'b1;
                  end else begin
                    if (e_lo < l_q || e_hi > r_q) begin
                      if (n_q >= MaxN) full_q <= 1'b1; else n_q <= n_q + 1'b1;
                    end
                    if (e_lo < l_q && e_hi > r_q) begin
                      split_q <= 1'b1; sp_lo_q <= r_q + 1'b1; sp_hi_q <= e_hi;
                    end
                  end
                end
                default: begin
                  if ((act_q == ActAll) ? (e_lo <= l_q && e_hi >= r_q)
                                        : (e_lo <= r_q && e_hi >= l_q)) hit_q <= 1'b1;
                end
              endcase
            end
            if (!((rdv_q && idx_q != '0) && ((act_q == ActFill && e_lo > r_q &&
                  e_hi >= l_q && !placed_q) ||
                  (act_q == ActClear && !(e_hi < l_q || e_lo > r_q) &&
                   e_lo < l_q && e_hi > r_q))))
              idx_q <= idx_q + 1'b1;
          end
        end
        SDone: begin
          state_q <= SIdle; out_v_q <= 1'b1;
          ans_q <= modify ? 1'b0 : hit_q;
          st_q <= (modify && full_q) ? StFull : StOk;
          if (modify && !full_q) begin
            bank_q <= ~bank_q; cnt_q <= n_q; used_q <= 5'(n_q);
          end else begin
            used_q <= 5'(cnt_q);
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign answer_o = ans_q;
  assign status_o = st_q;
  assign entries_used_o = used_q;

  `ISCT_ASSERT(a_no_accept_busy, in_valid_i && !in_stall_o |-> state_q == SIdle && !out_v_q)
  `ISCT_ASSERT_NEXT(a_done_out, state_q == SDone, out_v_q && state_q == SIdle)
  `ISCT_ASSERT(a_cnt_range, cnt_q <= MaxN)
endmodule

// ----- src/isct_mem.sv -----
// Two-bank interval store, registered read, ping-pong between banks
module isct_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     rd_bank_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic                     wr_bank_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i
);
  localparam int unsigned Slots = 2 ** ($clog2(Depth) + 1);

  logic [Width-1:0] mem_q [Slots];
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[{wr_bank_i, wr_addr_i}] <= wr_data_i;
    rd_data_o <= mem_q[{rd_bank_i, rd_addr_i}];
  end
endmodule

// ----- tb/sv/interval_set_coverage_table_checker.sv -----
// Checker for the interval set coverage table: models the set and compares results
module interval_set_coverage_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        answer_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  entries_used_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  import isct_pkg::*;

  localparam int Depth = MaxRangesDef;

  typedef struct packed {
    logic       answer;
    logic [1:0] status;
    logic [4:0] used;
  } outcome_t;

  logic [31:0] span_lo [Depth];
  logic [31:0] span_hi [Depth];
  int          span_cnt;
  outcome_t    awaited [$];

  function automatic outcome_t apply_action(logic [2:0] act, logic [31:0] l, logic [31:0] r);
    outcome_t    o;
    logic [31:0] nlo [Depth + 2];
    logic [31:0] nhi [Depth + 2];
    logic [31:0] mlo, mhi;
    int          n;
    bit          placed;
    o = '0;
    n = 0;
    placed = 0;
    mlo = l;
    mhi = r;
    if (act == ActPoint) begin
      for (int i = 0; i < span_cnt; i++)
        if (span_lo[i] <= l && span_hi[i] >= l) o.answer = 1;
    end else if (act <= ActAll) begin
      if (l > r) begin
        o.status = StBad;
      end else if (act == ActAny || act == ActAll) begin
        for (int i = 0; i < span_cnt; i++) begin
          if (act == ActAny && span_lo[i] <= r && span_hi[i] >= l) o.answer = 1;
          if (act == ActAll && span_lo[i] <= l && span_hi[i] >= r) o.answer = 1;
        end
      end else begin
        for (int i = 0; i < span_cnt; i++) begin
          if (act == ActFill) begin
            if (span_hi[i] < l) begin
              nlo[n] = span_lo[i]; nhi[n] = span_hi[i]; n++;
            end else if (span_lo[i] > r) begin
              if (!placed) begin
                nlo[n] = mlo; nhi[n] = mhi; n++; placed = 1;
              end
              nlo[n] = span_lo[i]; nhi[n] = span_hi[i]; n++;
            end else begin
              if (span_lo[i] < mlo) mlo = span_lo[i];
              if (span_hi[i] > mhi) mhi = span_hi[i];
            end
          end else if (span_hi[i] < l || span_lo[i] > r) begin
            nlo[n] = span_lo[i]; nhi[n] = span_hi[i]; n++;
          end else begin
            if (span_lo[i] < l) begin
              nlo[n] = span_lo[i]; nhi[n] = l - 1; n++;
            end
            if (span_hi[i] > r) begin
              nlo[n] = r + 1; nhi[n] = span_hi[i]; n++;
            end
          end
        end
        if (act == ActFill && !placed) begin
          nlo[n] = mlo; nhi[n] = mhi; n++;
        end
        if (n > Depth) begin
          o.status = StFull;
        end else begin
          for (int i = 0; i < n; i++) begin
            span_lo[i] = nlo[i];
            span_hi[i] = nhi[i];
          end
          span_cnt = n;
        end
      end
    end
    o.used = 5'(span_cnt);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e, a;
    if (!rst_ni) begin
      span_cnt = 0;
      awaited.delete();
      errors_o <= 0;
      results_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        awaited.push_back(apply_action(action_i, range_low_i, range_high_i));
      if (out_valid_i && !out_stall_i) begin
        a = '{answer_i, status_i, entries_used_i};
        results_o <= results_o + 1;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %p", $time, a);
          errors_o <= errors_o + 1;
        end else begin
          e = awaited.pop_front();
          if (e !== a) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= awaited.size();
    end
  end
endmodule

// ----- tb/sv/interval_set_coverage_table_tb.sv -----
// Testbench top for the interval set coverage table: stimulus and verdict
module interval_set_coverage_table_tb;
  import isct_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  action_i = '0;
  logic [31:0] range_low_i = '0;
  logic [31:0] range_high_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        answer_o;
  logic [1:0]  status_o;
  logic [4:0]  entries_used_o;
  int          errors, pending, results;
  int          send_idle, recv_idle;

  always #5 clk_i = ~clk_i;

  interval_set_coverage_table dut (.*);

  interval_set_coverage_table_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .range_low_i,
    .range_high_i, .out_valid_i(out_valid_o), .out_stall_i, .answer_i(answer_o),
    .status_i(status_o), .entries_used_i(entries_used_o), .errors_o(errors),
    .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle);

  task automatic send(logic [2:0] act, logic [31:0] l, logic [31:0] r);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= act;
    range_low_i <= l;
    range_high_i <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  function automatic logic [31:0] coord(int mode);
    case (mode)
      0: return $urandom_range(63);
      1: return 32'hFFFF_FFFF - $urandom_range(40);
      2: return $urandom_range(400);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_item(int mode);
    logic [31:0] a, b;
    logic [2:0]  act;
    a = coord(mode);
    b = ($urandom_range(9) == 0) ? coord(mode) : a + $urandom_range(12);
    if (b < a && $urandom_range(3) != 0) b = a;
    act = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    send(act, a, b);
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    send_idle = 6;
    recv_idle = 70;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty queries, extremes, merge, split, adjacency, bad range, unused actions, overflow
    send(ActPoint, 0, 0);
    send(ActAll, 0, 32'hFFFF_FFFF);
    send(ActFill, 0, 0);
    send(ActFill, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ActFill, 10, 20);
    send(ActFill, 21, 30);
    send(ActFill, 20, 21);
    send(ActClear, 15, 15);
    send(ActPoint, 15, 0);
    send(ActAny, 12, 18);
    send(ActAll, 16, 30);
    send(ActFill, 9, 5);
    send(ActClear, 9, 5);
    send(ActAny, 9, 5);
    send(ActAll, 9, 5);
    send(3'd5, 1, 2);
    send(3'd7, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 16; i++) send(ActFill, 100 + 4 * i, 101 + 4 * i);
    send(ActClear, 0, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) send(ActFill, 100 + 4 * i, 101 + 4 * i);
    send(ActClear, 101, 101);
    send(ActFill, 200, 200);
    send(ActClear, 0, 32'hFFFF_FFFF);
    drain();
    for (int k = 0; k < 1500; k++) begin
      if (k == 500) begin
        send_idle = 70;
        recv_idle = 6;
      end
      if (k == 1000) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (k % 300 == 299) drain();
      random_item(k % 4 == 3 ? 3 : (k / 150) % 3);
    end
    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered fill, clear and all queries incl. merge, split, overflow and bad ranges;");
    $display("%0d results checked under sender and receiver idling.", results);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
